### rtl/core/bffa_pkg.sv
// Shared types, codes and constants of the bitmap first-free allocator.
package bffa_pkg;

    localparam int COUNT_W       = 14;
    localparam int IDX_W         = COUNT_W + 1;
    localparam int MAP_BITS_DEF  = 8192;
    localparam int WORD_BITS_DEF = 32;
    localparam int S_TDATA_W     = 16;
    localparam int S_TUSER_W     = 2;
    localparam int M_TDATA_W     = 32;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 14'd8192;

    localparam logic [CFG_INDEX_W-1:0] REG_INODE_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 1'b1;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } mode_t;

    typedef enum logic {
        KIND_INODE = 1'b0,
        KIND_BLOCK = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_FULL         = 2'd1,
        STATUS_RANGE        = 2'd2,
        STATUS_ALREADY_FREE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    clear;
        logic    load;
        logic    issue;
        logic    write;
        logic    decide;
        status_t status;
        logic    push;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic range_err;
        logic issue_more;
        logic chk_valid;
        logic hit;
        logic bit_set;
        logic is_free;
        logic out_free;
    } sts_t;

endpackage

### rtl/core/bitmap_first_free_allocator.sv
// Allocator for two bitmaps, one of inodes and one of blocks, each one bit per entry.
// After reset the block runs a clearing pass over all MAP_BITS/WORD_BITS words (256 by default)
// with s_tready low; configuration writes are taken during it. An allocate request walks
// the chosen map from word 0, one word a cycle through that map's single-port RAM, and
// takes the lowest clear bit below min(count, MAP_BITS); a free request walks to the word
// that holds bit number-1. One request is worked on at a time; the next is accepted
// as soon as the result sits in the output register.
// Entries are numbered from 1; granted is 0 on every free and when the map is full.
module bitmap_first_free_allocator #(
    parameter int MAP_BITS  = bffa_pkg::MAP_BITS_DEF,
    parameter int WORD_BITS = bffa_pkg::WORD_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration: index 0 inode_count, index 1 block_count
    input  logic                               cfg_we,
    input  logic [bffa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bffa_pkg::COUNT_W-1:0]       cfg_wdata,
    // requests
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bffa_pkg::S_TDATA_W-1:0]     s_tdata,  // number[13:0], zero[15:14]
    input  logic [bffa_pkg::S_TUSER_W-1:0]     s_tuser,  // mode[0], kind[1]
    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bffa_pkg::M_TDATA_W-1:0]     m_tdata   // granted[13:0], status[15:14],
                                                         // free_left[29:16], zero[31:30]
);

    bffa_pkg::cmd_t cmd;
    bffa_pkg::sts_t sts;

    bffa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bffa_dpath #(
        .MAP_BITS  (MAP_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### rtl/core/bffa_ram.sv
// Generic single-port RAM with registered read data.
module bffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                            wdata,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/bffa_ctrl.sv
// Controller state machine: clearing pass, request capture, word scan and result hand-over.
module bffa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  bffa_pkg::sts_t      sts,
    output bffa_pkg::cmd_t      cmd
);

    bffa_pkg::state_t state_reg;
    bffa_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bffa_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bffa_pkg::ST_CLEAR: begin
                if (sts.clear_last) begin
                    state_next = bffa_pkg::ST_IDLE;
                end
            end
            bffa_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = bffa_pkg::ST_SCAN;
                end
            end
            bffa_pkg::ST_SCAN: begin
                if (sts.range_err || (sts.chk_valid && sts.hit) ||
                    (!sts.issue_more && !sts.chk_valid)) begin
                    state_next = bffa_pkg::ST_DONE;
                end
            end
            bffa_pkg::ST_DONE: begin
                if (sts.out_free) begin
                    state_next = bffa_pkg::ST_IDLE;
                end
            end
            default: state_next = bffa_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd        = '0;
        cmd.status = bffa_pkg::STATUS_OK;
        s_tready   = 1'b0;
        unique case (state_reg)
            bffa_pkg::ST_CLEAR: begin
                cmd.clear = 1'b1;
            end
            bffa_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            bffa_pkg::ST_SCAN: begin
                if (sts.range_err) begin
                    cmd.decide = 1'b1;
                    cmd.status = bffa_pkg::STATUS_RANGE;
                end else if (sts.chk_valid && sts.hit) begin
                    cmd.decide = 1'b1;
                    if (!sts.is_free || sts.bit_set) begin
                        cmd.write = 1'b1;
                    end else begin
                        cmd.status = bffa_pkg::STATUS_ALREADY_FREE;
                    end
                end else if (!sts.issue_more && !sts.chk_valid) begin
                    cmd.decide = 1'b1;
                    cmd.status = bffa_pkg::STATUS_FULL;
                end else begin
                    cmd.issue = sts.issue_more;
                end
            end
            bffa_pkg::ST_DONE: begin
                cmd.push = sts.out_free;
            end
            default: begin
                cmd.clear = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/bffa_dpath.sv
// Datapath: configuration, both bitmaps, used counters, word scan and result registers.
module bffa_dpath #(
    parameter int MAP_BITS  = bffa_pkg::MAP_BITS_DEF,
    parameter int WORD_BITS = bffa_pkg::WORD_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [bffa_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [bffa_pkg::COUNT_W-1:0]          cfg_wdata,
    input  logic [bffa_pkg::S_TDATA_W-1:0]        s_tdata,
    input  logic [bffa_pkg::S_TUSER_W-1:0]        s_tuser,
    input  logic                                  m_tready,
    output logic                                  m_tvalid,
    output logic [bffa_pkg::M_TDATA_W-1:0]        m_tdata,
    input  bffa_pkg::cmd_t                        cmd,
    output bffa_pkg::sts_t                        sts
);

    localparam int CW        = bffa_pkg::COUNT_W;
    localparam int IW        = bffa_pkg::IDX_W;
    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam logic [CW-1:0] LIM_MAX =
        CW'((MAP_BITS < (1 << CW)) ? MAP_BITS : ((1 << CW) - 1));
    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [IW-1:0] WORD_STEP = IW'(WORD_BITS);

    // configuration
    logic [CW-1:0] inode_count_reg;
    logic [CW-1:0] block_count_reg;

    // captured request
    bffa_pkg::mode_t mode_reg;
    bffa_pkg::kind_t kind_reg;
    logic [CW-1:0]   number_reg;
    logic [CW-1:0]   lim_reg;
    logic [CW-1:0]   count_sel;
    logic [CW-1:0]   lim_next;

    // scan
    logic [AW-1:0] issue_word_reg;
    logic [IW-1:0] issue_base_reg;
    logic [AW-1:0] chk_word_reg;
    logic [IW-1:0] chk_base_reg;
    logic          chk_valid_reg;
    logic [AW-1:0] clr_word_reg;

    // used counters and results
    logic [CW-1:0]     inodes_used_reg;
    logic [CW-1:0]     blocks_used_reg;
    logic [CW-1:0]     used_sel;
    logic [CW-1:0]     used_next;
    logic [CW-1:0]     left_next;
    logic [CW-1:0]     granted_next;
    logic [CW-1:0]     res_granted_reg;
    bffa_pkg::status_t res_status_reg;
    logic [CW-1:0]     res_left_reg;
    logic              out_valid_reg;
    logic [CW-1:0]     out_granted_reg;
    bffa_pkg::status_t out_status_reg;
    logic [CW-1:0]     out_left_reg;

    // bitmap access
    logic [AW-1:0]        ram_addr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 inode_we;
    logic                 block_we;
    logic [WORD_BITS-1:0] inode_rdata;
    logic [WORD_BITS-1:0] block_rdata;
    logic [WORD_BITS-1:0] rdata;

    logic [IW-1:0]        lim_ext;
    logic [IW-1:0]        idx_ext;
    logic [IW-1:0]        rem;
    logic [IW-1:0]        diff;
    logic [OFF_W-1:0]     off;
    logic [OFF_W-1:0]     pos;
    logic [OFF_W-1:0]     wr_pos;
    logic                 found;
    logic                 in_word;
    logic                 is_free;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] wr_word;
    logic [IW-1:0]        grant_sum;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inode_count_reg <= bffa_pkg::COUNT_RESET;
            block_count_reg <= bffa_pkg::COUNT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bffa_pkg::REG_INODE_COUNT: inode_count_reg <= cfg_wdata;
                bffa_pkg::REG_BLOCK_COUNT: block_count_reg <= cfg_wdata;
                default: inode_count_reg <= inode_count_reg;
            endcase
        end
    end

    // clamp the configured count to the map size
    always_comb begin
        count_sel = bffa_pkg::kind_t'(s_tuser[1]) == bffa_pkg::KIND_BLOCK ?
                    block_count_reg : inode_count_reg;
        lim_next  = (32'(count_sel) > 32'(MAP_BITS)) ? LIM_MAX : count_sel;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= bffa_pkg::mode_t'(s_tuser[0]);
            kind_reg   <= bffa_pkg::kind_t'(s_tuser[1]);
            number_reg <= s_tdata[CW-1:0];
            lim_reg    <= lim_next;
        end
    end

    // clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_word_reg <= '0;
        end else if (cmd.clear && !sts.clear_last) begin
            clr_word_reg <= clr_word_reg + AW'(1);
        end
    end

    // word walk: issue one read a cycle, check it the next
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            issue_word_reg <= '0;
            issue_base_reg <= '0;
            chk_valid_reg  <= 1'b0;
        end else begin
            chk_valid_reg <= cmd.issue;
            if (cmd.issue) begin
                issue_word_reg <= issue_word_reg + AW'(1);
                issue_base_reg <= issue_base_reg + WORD_STEP;
                chk_word_reg   <= issue_word_reg;
                chk_base_reg   <= issue_base_reg;
            end
        end
    end

    always_comb begin
        ram_addr = issue_word_reg;
        if (cmd.clear) begin
            ram_addr = clr_word_reg;
        end else if (cmd.write) begin
            ram_addr = chk_word_reg;
        end
        ram_wdata = cmd.clear ? '0 : wr_word;
        inode_we  = cmd.clear || (cmd.write && kind_reg == bffa_pkg::KIND_INODE);
        block_we  = cmd.clear || (cmd.write && kind_reg == bffa_pkg::KIND_BLOCK);
    end

    bffa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_inode_map (
        .aclk  (aclk),
        .we    (inode_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (inode_rdata)
    );

    bffa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_block_map (
        .aclk  (aclk),
        .we    (block_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (block_rdata)
    );

    assign rdata   = (kind_reg == bffa_pkg::KIND_BLOCK) ? block_rdata : inode_rdata;
    assign is_free = (mode_reg == bffa_pkg::MODE_FREE);
    assign lim_ext = {1'b0, lim_reg};
    assign idx_ext = {1'b0, number_reg - CW'(1)};

    // lowest clear bit of the checked word that still lies below the limit
    always_comb begin
        rem   = lim_ext - chk_base_reg;
        found = 1'b0;
        pos   = '0;
        for (int p = WORD_BITS - 1; p >= 0; p--) begin
            if (!rdata[p] && (IW'(p) < rem)) begin
                found = 1'b1;
                pos   = OFF_W'(p);
            end
        end
    end

    // position of the entry to free relative to the checked word
    always_comb begin
        diff    = idx_ext - chk_base_reg;
        in_word = (idx_ext >= chk_base_reg) && (diff < WORD_STEP);
        off     = diff[OFF_W-1:0];
    end

    always_comb begin
        wr_pos  = is_free ? off : pos;
        mask    = {{(WORD_BITS - 1){1'b0}}, 1'b1} << wr_pos;
        wr_word = is_free ? (rdata & ~mask) : (rdata | mask);
    end

    always_comb begin
        sts.clear_last = (clr_word_reg == LAST_WORD);
        sts.range_err  = is_free && ((number_reg == '0) || (number_reg > lim_reg));
        sts.issue_more = is_free ? (issue_base_reg <= idx_ext) : (issue_base_reg < lim_ext);
        sts.chk_valid  = chk_valid_reg;
        sts.hit        = is_free ? in_word : found;
        sts.bit_set    = in_word && rdata[off];
        sts.is_free    = is_free;
        sts.out_free   = !out_valid_reg || m_tready;
    end

    // counter update and remaining free entries
    always_comb begin
        used_sel  = (kind_reg == bffa_pkg::KIND_BLOCK) ? blocks_used_reg : inodes_used_reg;
        used_next = used_sel;
        if (cmd.status == bffa_pkg::STATUS_OK) begin
            used_next = is_free ? used_sel - CW'(1) : used_sel + CW'(1);
        end
        left_next    = (lim_reg > used_next) ? lim_reg - used_next : '0;
        grant_sum    = chk_base_reg + IW'(pos) + IW'(1);
        granted_next = (!is_free && cmd.status == bffa_pkg::STATUS_OK) ?
                       grant_sum[CW-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inodes_used_reg <= '0;
            blocks_used_reg <= '0;
        end else if (cmd.decide) begin
            if (kind_reg == bffa_pkg::KIND_BLOCK) begin
                blocks_used_reg <= used_next;
            end else begin
                inodes_used_reg <= used_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            res_granted_reg <= granted_next;
            res_status_reg  <= cmd.status;
            res_left_reg    <= left_next;
        end
    end

    // output register: hold until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            out_granted_reg <= res_granted_reg;
            out_status_reg  <= res_status_reg;
            out_left_reg    <= res_left_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_left_reg, out_status_reg, out_granted_reg};

endmodule

### rtl/core/bffa_checker.sv
// Port checker for the allocator, bound to the top level.
module bffa_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bffa_pkg::M_TDATA_W-1:0] m_tdata
);

    // nothing offered or taken straight after reset: the clearing pass runs first
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("transfer possible straight after reset");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // only a successful allocate carries a granted number
    a_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[15:14] != bffa_pkg::STATUS_OK) |-> m_tdata[13:0] == '0)
        else $error("granted number with a failing status");

    // one request at a time: the scan follows every accepted transfer
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted during a scan");

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
